// ===== rtl/wtdf_pkg.sv =====
// Shared constants, types and the wheel table of the trial-division factorizer.
package wtdf_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_FACTORS = 32;
    localparam int DATA_BITS   = ((VALUE_BITS + 7) / 8) * 8;
    localparam int COUNT_BITS  = $clog2(MAX_FACTORS);
    localparam int DIV_CNT_BITS = $clog2(VALUE_BITS + 1);

    localparam int POS_BITS  = 4;
    localparam int STEP_BITS = 3;
    localparam logic [POS_BITS-1:0] WHEEL_LAST = 4'd10;
    localparam logic [POS_BITS-1:0] WHEEL_LOOP = 4'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [VALUE_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quot;
        logic [VALUE_BITS-1:0] rem;
    } t_div_res;

    // Candidate increments: 1,2,2 to reach 7, then the mod-30 wheel cycle.
    function automatic logic [STEP_BITS-1:0] wheel_step(input logic [POS_BITS-1:0] pos);
        logic [STEP_BITS-1:0] step;
        case (pos)
            4'd0:    step = 3'd1;
            4'd1:    step = 3'd2;
            4'd2:    step = 3'd2;
            4'd3:    step = 3'd4;
            4'd4:    step = 3'd2;
            4'd5:    step = 3'd4;
            4'd6:    step = 3'd2;
            4'd7:    step = 3'd4;
            4'd8:    step = 3'd6;
            4'd9:    step = 3'd2;
            4'd10:   step = 3'd6;
            default: step = 3'd2;
        endcase
        return step;
    endfunction

endpackage

// ===== rtl/wtdf_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module wtdf_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wtdf_pkg::t_div_req  i_req,
    output wtdf_pkg::t_div_res  o_res
);
    import wtdf_pkg::*;

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic [VALUE_BITS-1:0]   r_quot, n_quot;
    logic [VALUE_BITS-1:0]   r_rem, n_rem;
    logic [VALUE_BITS-1:0]   r_divisor, n_divisor;
    logic [VALUE_BITS:0]     trial;
    logic [VALUE_BITS:0]     diff;

    assign trial = {r_rem, r_quot[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, r_divisor};

    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_cnt     = r_cnt;
        n_quot    = r_quot;
        n_rem     = r_rem;
        n_divisor = r_divisor;
        if (i_req.start) begin
            n_busy    = 1'b1;
            n_cnt     = DIV_CNT_BITS'(VALUE_BITS);
            n_quot    = i_req.dividend;
            n_rem     = '0;
            n_divisor = i_req.divisor;
        end else if (r_busy) begin
            // The partial remainder stays below the divisor, so it fits the word.
            if (!diff[VALUE_BITS]) begin
                n_rem  = diff[VALUE_BITS-1:0];
                n_quot = {r_quot[VALUE_BITS-2:0], 1'b1};
            end else begin
                n_rem  = trial[VALUE_BITS-1:0];
                n_quot = {r_quot[VALUE_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot    <= n_quot;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

// ===== rtl/wheel_trial_division_factorizer.sv =====
// Trial-division factorizer on a 2-3-5 wheel with a shared iterative divider.
// Each trial runs one division: the sequencer starts the divider, waits while it
// works through the quotient bits, then tests the result. Each factor is
// presented in the output state, which holds while m_tready is low; a prime
// near 2^32 takes about 17500 trials. One word is in work at a time and
// s_tready is high only when idle. Synchronous reset returns to idle.
module wheel_trial_division_factorizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wtdf_pkg::DATA_BITS-1:0] s_tdata,  // [VALUE_BITS-1:0] value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wtdf_pkg::DATA_BITS-1:0] m_tdata,  // [VALUE_BITS-1:0] factor
    output logic                          m_tlast
);
    import wtdf_pkg::*;

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_rest, n_rest;
    logic [VALUE_BITS-1:0] r_cand, n_cand;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [VALUE_BITS-1:0] r_factor, n_factor;
    logic                  r_last, n_last;
    t_div_req              div_req;
    t_div_res              div_res;
    logic                  keep_trying;

    wtdf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    assign div_req.start    = (r_state == S_START);
    assign div_req.dividend = r_rest;
    assign div_req.divisor  = r_cand;

    // Candidate at most rest / candidate is the overflow-free form of cand^2 <= rest.
    assign keep_trying = (r_count < COUNT_BITS'(MAX_FACTORS - 1)) && (r_cand <= div_res.quot);

    always_comb begin
        n_state  = r_state;
        n_rest   = r_rest;
        n_cand   = r_cand;
        n_pos    = r_pos;
        n_count  = r_count;
        n_factor = r_factor;
        n_last   = r_last;
        case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_rest  = s_tdata[VALUE_BITS-1:0];
                    n_cand  = VALUE_BITS'(2);
                    n_pos   = '0;
                    n_count = '0;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (div_res.done) begin
                    if (keep_trying) begin
                        if (div_res.rem == '0) begin
                            n_factor = r_cand;
                            n_last   = 1'b0;
                            n_rest   = div_res.quot;
                            n_state  = S_OUT;
                        end else begin
                            n_cand  = r_cand + VALUE_BITS'(wheel_step(r_pos));
                            n_pos   = (r_pos == WHEEL_LAST) ? WHEEL_LOOP : r_pos + 1'b1;
                            n_state = S_START;
                        end
                    end else begin
                        n_factor = r_rest;
                        n_last   = 1'b1;
                        n_state  = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_state = S_START;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_last  <= n_last;
        end
        r_rest   <= n_rest;
        r_cand   <= n_cand;
        r_factor <= n_factor;
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = (r_state == S_OUT);
    assign m_tlast  = r_last;

    always_comb begin
        m_tdata                 = '0;
        m_tdata[VALUE_BITS-1:0] = r_factor;
    end

    // The divider only reports while the sequencer is waiting for it.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> r_state == S_WAIT)
        else $error("divider result arrived outside the wait state");

    // Input and output sides are never open in the same cycle.
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a factor is presented");

    // A divisor found by trial is always a real candidate.
    a_trial_factor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tlast) |-> r_factor >= VALUE_BITS'(2))
        else $error("non-final factor below two");

    // The factor budget leaves room for the final remainder.
    a_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tlast) |-> r_count < COUNT_BITS'(MAX_FACTORS - 1))
        else $error("factor budget exceeded");

    // The candidate only grows within one input word.
    a_cand_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START && $past(r_state) == S_WAIT) |-> r_cand > $past(r_cand))
        else $error("candidate did not advance");

endmodule
